// File: hdl/signed_fields_to_ascii_frame_assert.svh
// Assertion macros for the control frame formatter.
`ifndef SIGNED_FIELDS_TO_ASCII_FRAME_ASSERT_SVH
`define SIGNED_FIELDS_TO_ASCII_FRAME_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SFAF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfaf: assertion failed");
// next-cycle implication
`define SFAF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfaf: assertion failed");
`else
`define SFAF_ASSERT_IMP(label, clk, rst, ante, cons)
`define SFAF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/sfaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sfaf_pkg;

  localparam int NUM_FIELDS = 5;
  localparam int FLD_PAN   = 0;
  localparam int FLD_TILT  = 1;
  localparam int FLD_LASER = 2;
  localparam int FLD_DRIVE = 3;
  localparam int FLD_RAD   = 4;
  localparam logic [2:0] LAST_FIELD = 3'd4;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic signed [2:0]  SPEED_MAX = 3'sd2;
  localparam logic signed [9:0]  DRIVE_MAX = 10'sd500;
  localparam logic signed [12:0] RAD_MAX   = 13'sd2100;

  // one value: sign, index of its leading digit, four BCD digits (dig[3] = thousands)
  typedef struct packed {
    logic            neg;
    logic [1:0]      top;
    logic [3:0][3:0] dig;
  } field_t;

  typedef struct packed {
    field_t [NUM_FIELDS-1:0] fld;
  } frame_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [11:0] rem;
  } split_t;

  typedef enum logic [1:0] {
    S_HEAD,
    S_SIGN,
    S_DIGIT,
    S_SEP
  } back_state_t;

  // One decimal digit of v at the given place value (v < 10 * place).
  // Nine independent compares, then pick the largest match.
  function automatic split_t dec_split(input logic [11:0] v, input logic [11:0] place);
    split_t      r;
    logic [13:0] step;
    r.digit = '0;
    r.rem   = v;
    for (int k = 1; k <= 9; k++) begin
      step = 14'(k) * {2'b00, place};
      if ({2'b00, v} >= step) begin
        r.digit = 4'(k);
        r.rem   = 12'({2'b00, v} - step);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/sfaf_front.sv
`timescale 1ns / 1ps
`default_nettype none
`include "signed_fields_to_ascii_frame_assert.svh"
module sfaf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic signed [2:0]    pan_speed,
  input  logic signed [2:0]    tilt_speed,
  input  logic                 laser_on,
  input  logic signed [9:0]    drive_speed,
  input  logic signed [12:0]   turn_radius,
  output logic                 frame_valid,
  output sfaf_pkg::frame_t     frame,
  input  logic                 q_full
);
  import sfaf_pkg::*;

  logic en;
  logic v1, v2, v3, v4;
  frame_t f1, f2, f3, f4;
  frame_t f1_in, f2_in, f3_in, f4_in;
  logic [8:0]  dmag1;
  logic [11:0] rmag1;
  logic [6:0]  drem2;
  logic [9:0]  rrem2;
  logic [6:0]  rrem3;

  logic signed [2:0]  pan_c, tilt_c, pan_a, tilt_a;
  logic signed [9:0]  drv_c, drv_a;
  logic signed [12:0] rad_c, rad_a;
  split_t sp_dh, sp_rk, sp_dt, sp_rh, sp_rt;

  // whole pipe moves unless the last stage is blocked by the queue
  assign en          = !(v4 && q_full);
  assign full        = !en;
  assign frame_valid = v4;
  assign frame       = f4;

  // stage 1: saturate, sign/magnitude
  always_comb begin
    pan_c  = (pan_speed < -SPEED_MAX) ? -SPEED_MAX :
             (pan_speed > SPEED_MAX) ? SPEED_MAX : pan_speed;
    tilt_c = (tilt_speed < -SPEED_MAX) ? -SPEED_MAX :
             (tilt_speed > SPEED_MAX) ? SPEED_MAX : tilt_speed;
    drv_c  = (drive_speed < -DRIVE_MAX) ? -DRIVE_MAX :
             (drive_speed > DRIVE_MAX) ? DRIVE_MAX : drive_speed;
    rad_c  = (turn_radius < -RAD_MAX) ? -RAD_MAX :
             (turn_radius > RAD_MAX) ? RAD_MAX : turn_radius;
    pan_a  = pan_c[2]  ? -pan_c  : pan_c;
    tilt_a = tilt_c[2] ? -tilt_c : tilt_c;
    drv_a  = drv_c[9]  ? -drv_c  : drv_c;
    rad_a  = rad_c[12] ? -rad_c  : rad_c;

    f1_in = '0;
    f1_in.fld[FLD_PAN].neg     = pan_c[2];
    f1_in.fld[FLD_PAN].dig[0]  = {2'b00, pan_a[1:0]};
    f1_in.fld[FLD_TILT].neg    = tilt_c[2];
    f1_in.fld[FLD_TILT].dig[0] = {2'b00, tilt_a[1:0]};
    f1_in.fld[FLD_LASER].dig[0] = {3'b000, laser_on};
    f1_in.fld[FLD_DRIVE].neg   = drv_c[9];
    f1_in.fld[FLD_RAD].neg     = rad_c[12];
  end

  // stage 2: radius thousands, drive hundreds
  always_comb begin
    sp_dh = dec_split({3'b000, dmag1}, 12'd100);
    sp_rk = dec_split(rmag1, 12'd1000);
    f2_in = f1;
    f2_in.fld[FLD_DRIVE].dig[2] = sp_dh.digit;
    f2_in.fld[FLD_RAD].dig[3]   = sp_rk.digit;
  end

  // stage 3: radius hundreds, drive tens and ones
  always_comb begin
    sp_dt = dec_split({5'b00000, drem2}, 12'd10);
    sp_rh = dec_split({2'b00, rrem2}, 12'd100);
    f3_in = f2;
    f3_in.fld[FLD_DRIVE].dig[1] = sp_dt.digit;
    f3_in.fld[FLD_DRIVE].dig[0] = sp_dt.rem[3:0];
    f3_in.fld[FLD_DRIVE].top    = (f2.fld[FLD_DRIVE].dig[2] != 4'd0) ? 2'd2 :
                                  (sp_dt.digit != 4'd0) ? 2'd1 : 2'd0;
    f3_in.fld[FLD_RAD].dig[2]   = sp_rh.digit;
  end

  // stage 4: radius tens and ones
  always_comb begin
    sp_rt = dec_split({5'b00000, rrem3}, 12'd10);
    f4_in = f3;
    f4_in.fld[FLD_RAD].dig[1] = sp_rt.digit;
    f4_in.fld[FLD_RAD].dig[0] = sp_rt.rem[3:0];
    f4_in.fld[FLD_RAD].top    = (f3.fld[FLD_RAD].dig[3] != 4'd0) ? 2'd3 :
                                (f3.fld[FLD_RAD].dig[2] != 4'd0) ? 2'd2 :
                                (sp_rt.digit != 4'd0) ? 2'd1 : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1    <= f1_in;
      dmag1 <= drv_a[8:0];
      rmag1 <= rad_a[11:0];
      f2    <= f2_in;
      drem2 <= sp_dh.rem[6:0];
      rrem2 <= sp_rk.rem[9:0];
      f3    <= f3_in;
      rrem3 <= sp_rh.rem[6:0];
      f4    <= f4_in;
    end
  end

  `SFAF_ASSERT_NXT(a_stall_keeps_frame, clk, rst, v4 && q_full, v4)
  `SFAF_ASSERT_IMP(a_drive_three_digits, clk, rst, v4, f4.fld[FLD_DRIVE].top != 2'd3)

endmodule
`default_nettype wire

// File: hdl/sfaf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "signed_fields_to_ascii_frame_assert.svh"
module sfaf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `SFAF_ASSERT_IMP(a_no_overflow, clk, rst, wr, !full)
  `SFAF_ASSERT_IMP(a_no_underflow, clk, rst, rd, !empty)

endmodule
`default_nettype wire

// File: hdl/sfaf_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "signed_fields_to_ascii_frame_assert.svh"
module sfaf_back (
  input  logic             clk,
  input  logic             rst,
  input  sfaf_pkg::frame_t head,
  input  logic             q_empty,
  output logic             q_pop,
  output logic [7:0]       frame_byte,
  output logic             last_byte,
  output logic             empty,
  input  logic             pop
);
  import sfaf_pkg::*;

  back_state_t state, state_next;
  logic [2:0]  f, f_next, nf;
  logic [1:0]  p, p_next;
  logic        ovalid;
  logic        out_free;
  logic        load;
  logic [7:0]  byte_val;
  logic        byte_last;
  field_t      cur;
  logic [7:0]  digit_ch;

  assign out_free = !ovalid || pop;
  assign empty    = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_HEAD;
      f      <= '0;
      p      <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      f     <= f_next;
      p     <= p_next;
      if (load) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte <= byte_val;
      last_byte  <= byte_last;
    end
  end

  always_comb begin
    cur        = head.fld[f];
    digit_ch   = CH_ZERO | {4'b0000, cur.dig[p]};
    nf         = (f == LAST_FIELD) ? '0 : f + 3'd1;
    state_next = state;
    f_next     = f;
    p_next     = p;
    load       = 1'b0;
    byte_val   = CH_HASH;
    byte_last  = 1'b0;
    q_pop      = 1'b0;
    case (state)
      S_HEAD: begin
        if (!q_empty && out_free) begin
          load       = 1'b1;
          byte_val   = CH_HASH;
          f_next     = '0;
          p_next     = head.fld[0].top;
          state_next = S_SIGN;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          load = 1'b1;
          if (cur.neg) begin
            byte_val   = CH_MINUS;
            state_next = S_DIGIT;
          end else begin
            byte_val = digit_ch;
            if (p == 2'd0) begin
              state_next = S_SEP;
            end else begin
              p_next     = p - 2'd1;
              state_next = S_DIGIT;
            end
          end
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          load     = 1'b1;
          byte_val = digit_ch;
          if (p == 2'd0) begin
            state_next = S_SEP;
          end else begin
            p_next = p - 2'd1;
          end
        end
      end
      S_SEP: begin
        if (out_free) begin
          load = 1'b1;
          if (f == LAST_FIELD) begin
            byte_val   = CH_PCT;
            byte_last  = 1'b1;
            q_pop      = 1'b1;
            state_next = S_HEAD;
          end else begin
            byte_val   = CH_BAR;
            f_next     = nf;
            p_next     = head.fld[nf].top;
            state_next = S_SIGN;
          end
        end
      end
      default: begin
        state_next = S_HEAD;
      end
    endcase
  end

  `SFAF_ASSERT_IMP(a_pop_has_frame, clk, rst, q_pop, !q_empty)
  `SFAF_ASSERT_NXT(a_close_to_head, clk, rst, load && byte_last, state == S_HEAD)

endmodule
`default_nettype wire

// File: hdl/signed_fields_to_ascii_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake            Payload
// input     push / full          pan_speed, tilt_speed, laser_on, drive_speed, turn_radius
// result    empty / pop          frame_byte, last_byte (high on the closing '%')
//
// Each item becomes one ASCII frame of 11 to 20 bytes, sent one byte per cycle while pop is held.
// The front is a four-stage pipe (saturate, then one decimal digit split per stage)
// and takes an item every cycle until the frame queue fills.
// Sustained rate is set by the back sequencer, one frame byte at a time; a transfer in
// passes the four front stages, the queue and the output register before its first byte shows.
// Reset (rst, synchronous) clears the pipe valids, queue pointers and sequencer.
// A stall on pop holds the output byte; the queue then backs up into the front.
module signed_fields_to_ascii_frame #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic signed [2:0]   pan_speed,
  input  logic signed [2:0]   tilt_speed,
  input  logic                laser_on,
  input  logic signed [9:0]   drive_speed,
  input  logic signed [12:0]  turn_radius,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          frame_byte,
  output logic                last_byte
);
  import sfaf_pkg::*;

  // front to queue
  logic   fr_valid;
  frame_t fr_frame;
  logic   q_full;
  logic   q_wr;

  // queue to back
  frame_t q_head;
  logic   q_empty;
  logic   q_pop;

  // a classified frame moves into the queue whenever there is room
  assign q_wr = fr_valid && !q_full;

  sfaf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pan_speed   (pan_speed),
    .tilt_speed  (tilt_speed),
    .laser_on    (laser_on),
    .drive_speed (drive_speed),
    .turn_radius (turn_radius),
    .frame_valid (fr_valid),
    .frame       (fr_frame),
    .q_full      (q_full)
  );

  // short decoupling queue of formatted-digit descriptors
  sfaf_queue #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (fr_frame),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  // byte sequencer with registered output stage
  sfaf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
`default_nettype wire

// File: test/signed_fields_to_ascii_frame_checker.sv
`timescale 1ns / 1ps
module signed_fields_to_ascii_frame_checker
  import sfaf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic signed [2:0]  pan_speed,
  input  logic signed [2:0]  tilt_speed,
  input  logic               laser_on,
  input  logic signed [9:0]  drive_speed,
  input  logic signed [12:0] turn_radius,
  input  logic               empty,
  input  logic               pop,
  input  logic [7:0]         frame_byte,
  input  logic               last_byte,
  output int                 fail_count,
  output int                 pending_bytes,
  output int                 frames_in,
  output int                 bytes_out
);

  localparam int MAX_REPORTS = 20;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } frame_char_t;

  frame_char_t chars_due[$];
  int          mismatches = 0;
  int          n_frames   = 0;
  int          n_bytes    = 0;

  initial begin
    fail_count    = 0;
    pending_bytes = 0;
    frames_in     = 0;
    bytes_out     = 0;
  end

  function automatic int saturate(input int v, input int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic queue_char(input logic [7:0] ch, input logic last);
    frame_char_t c;
    c.ch   = ch;
    c.last = last;
    chars_due.push_back(c);
  endtask

  // sign, then digits of the magnitude, no leading zeros
  task automatic queue_value(input int v);
    int mag;
    int place;
    int d;
    bit started;
    started = 1'b0;
    place   = 1000;
    if (v < 0) begin
      queue_char(CH_MINUS, 1'b0);
      mag = -v;
    end else begin
      mag = v;
    end
    for (int k = 0; k < 4; k++) begin
      d   = mag / place;
      mag = mag - d * place;
      if (d != 0 || started || place == 1) begin
        started = 1'b1;
        queue_char(CH_ZERO + 8'(d), 1'b0);
      end
      place = place / 10;
    end
  endtask

  task automatic queue_frame();
    queue_char(CH_HASH, 1'b0);
    queue_value(saturate(int'(pan_speed), int'(SPEED_MAX)));
    queue_char(CH_BAR, 1'b0);
    queue_value(saturate(int'(tilt_speed), int'(SPEED_MAX)));
    queue_char(CH_BAR, 1'b0);
    queue_value(laser_on ? 1 : 0);
    queue_char(CH_BAR, 1'b0);
    queue_value(saturate(int'(drive_speed), int'(DRIVE_MAX)));
    queue_char(CH_BAR, 1'b0);
    queue_value(saturate(int'(turn_radius), int'(RAD_MAX)));
    queue_char(CH_PCT, 1'b1);
  endtask

  always @(posedge clk) begin : watch
    frame_char_t want;
    if (!rst) begin
      // output side first: a frame entering now cannot leave at this edge
      if (pop && !empty) begin
        n_bytes++;
        if (chars_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected output byte, expected none, actual %h last %b",
                     $time, frame_byte, last_byte);
        end else begin
          want = chars_due.pop_front();
          if (frame_byte !== want.ch) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: frame_byte mismatch, expected %h, actual %h",
                       $time, want.ch, frame_byte);
          end
          if (last_byte !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: last_byte mismatch, expected %b, actual %b",
                       $time, want.last, last_byte);
          end
        end
      end
      if (push && !full) begin
        n_frames++;
        queue_frame();
      end
    end
    fail_count    <= mismatches;
    pending_bytes <= chars_due.size();
    frames_in     <= n_frames;
    bytes_out     <= n_bytes;
  end

endmodule

// File: test/tb_signed_fields_to_ascii_frame.sv
`timescale 1ns / 1ps
module tb_signed_fields_to_ascii_frame;
  import sfaf_pkg::*;

  // Slowest run: ~300 frames x 20 bytes with the receiver idle 82 percent of the time,
  // plus the long hold; the limit is many times that.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 280;
  localparam int LONG_HOLD    = 300;  // receiver hold-off, in cycles
  localparam int TAIL_CYCLES  = 40;   // wait after the drain for stray bytes

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic signed [2:0]  pan_speed = '0;
  logic signed [2:0]  tilt_speed = '0;
  logic               laser_on = 1'b0;
  logic signed [9:0]  drive_speed = '0;
  logic signed [12:0] turn_radius = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         frame_byte;
  logic               last_byte;

  int fail_count;
  int pending_bytes;
  int frames_in;
  int bytes_out;

  // idle rates in percent; changed by the sender between phases
  int  send_idle = 19;
  int  recv_idle = 82;
  logic hold_request = 1'b0;
  int  cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  signed_fields_to_ascii_frame dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pan_speed   (pan_speed),
    .tilt_speed  (tilt_speed),
    .laser_on    (laser_on),
    .drive_speed (drive_speed),
    .turn_radius (turn_radius),
    .empty       (empty),
    .pop         (pop),
    .frame_byte  (frame_byte),
    .last_byte   (last_byte)
  );

  signed_fields_to_ascii_frame_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .pan_speed     (pan_speed),
    .tilt_speed    (tilt_speed),
    .laser_on      (laser_on),
    .drive_speed   (drive_speed),
    .turn_radius   (turn_radius),
    .empty         (empty),
    .pop           (pop),
    .frame_byte    (frame_byte),
    .last_byte     (last_byte),
    .fail_count    (fail_count),
    .pending_bytes (pending_bytes),
    .frames_in     (frames_in),
    .bytes_out     (bytes_out)
  );

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still due", cycles, pending_bytes);
      $display("tb_signed_fields_to_ascii_frame failed");
      $finish;
    end
  end

  // Receiver: pops at random; once asked, stops popping while hold_left counts down, so
  // the frame queue and the front pipe back up and full rises.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= (int'($urandom_range(99)) >= recv_idle);
      end
    end
  end

  // One transfer on the input side. Gaps go in before the item; push is never
  // dropped and raised in the same step.
  task automatic send_frame(input int pan, input int tilt, input int laser,
                            input int drive, input int radius);
    while (int'($urandom_range(99)) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    pan_speed   <= 3'(pan);
    tilt_speed  <= 3'(tilt);
    laser_on    <= 1'(laser);
    drive_speed <= 10'(drive);
    turn_radius <= 13'(radius);
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Mostly in range, some raw codes so the saturation path and every bit get hit.
  function automatic logic signed [2:0] pick_speed();
    if ($urandom_range(9) < 7) return 3'(int'($urandom_range(4)) - 2);
    return 3'($urandom);
  endfunction

  function automatic logic signed [9:0] pick_drive();
    case ($urandom_range(4))
      0: return 10'($urandom);                              // raw, may saturate
      1: return 10'(int'($urandom_range(18)) - 9);          // one digit
      2: return 10'(int'($urandom_range(198)) - 99);        // up to two digits
      default: return 10'(int'($urandom_range(1000)) - 500);
    endcase
  endfunction

  function automatic logic signed [12:0] pick_radius();
    case ($urandom_range(5))
      0: return 13'($urandom);                              // raw, may saturate
      1: return 13'(int'($urandom_range(18)) - 9);
      2: return 13'(int'($urandom_range(1998)) - 999);      // up to three digits
      3: return 13'(int'($urandom_range(40)) - 20 + ($urandom_range(1) ? 1000 : -1000));
      default: return 13'(int'($urandom_range(4200)) - 2100);
    endcase
  endfunction

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames: zero, longest, range ends, saturation, digit-count edges.
    send_frame(0, 0, 0, 0, 0);
    send_frame(-2, -2, 1, -500, -2100);
    send_frame(2, 2, 1, 500, 2100);
    send_frame(-4, 3, 0, -512, -4096);
    send_frame(3, -4, 1, 511, 4095);
    send_frame(-3, -1, 0, -501, -2101);
    send_frame(1, -1, 1, 501, 2101);
    send_frame(0, 1, 0, 9, -9);
    send_frame(-1, 0, 1, -10, 10);
    send_frame(0, 0, 0, 99, -99);
    send_frame(0, 0, 1, -100, 100);
    send_frame(0, 0, 0, 100, -999);
    send_frame(1, 1, 0, -1, 1000);
    send_frame(0, 0, 1, 1, -1000);
    send_frame(2, -2, 0, -499, 1999);
    send_frame(0, 0, 0, 250, -2099);
    send_frame(-2, 2, 1, 7, 2000);
    send_frame(0, 0, 0, -90, 1009);
    send_frame(0, 0, 1, 0, -1);

    // Random frames in three idle patterns.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle <= 82;
        recv_idle <= 19;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle    <= 0;
        recv_idle    <= 0;
        hold_request <= 1'b1;  // long output stall while input keeps coming
      end
      send_frame(int'(pick_speed()), int'(pick_speed()), int'($urandom_range(1)),
                 int'(pick_drive()), int'(pick_radius()));
    end
    push <= 1'b0;

    // Drain, then a short tail for stray bytes.
    while (pending_bytes != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d frames in, %0d bytes out, checked through two skewed idle mixes,", frames_in,
             bytes_out);
    $display("a back-to-back phase and a %0d-cycle output hold-off", LONG_HOLD);
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("tb_signed_fields_to_ascii_frame passed");
    end else begin
      $display("tb_signed_fields_to_ascii_frame failed");
    end
    $finish;
  end

endmodule
